// ===== rtl/fcvm_pkg.sv =====
// Shared types and constants for the fly camera view matrix engine.
`timescale 1ns / 1ps
package fcvm_pkg;

  // command codes
  localparam logic [1:0] CMD_KEY    = 2'd0;
  localparam logic [1:0] CMD_MOUSE  = 2'd1;
  localparam logic [1:0] CMD_SETPOS = 2'd2;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_SENS  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED = 4'd1;

  localparam logic [15:0] SENS_RST  = 16'd6554;
  localparam logic [15:0] SPEED_RST = 16'd640;

  // angles, Q.16 degrees
  localparam logic signed [31:0] DEG89  = 32'sd5832704;
  localparam logic signed [31:0] DEG90  = 32'sd5898240;
  localparam logic signed [31:0] DEG180 = 32'sd11796480;
  localparam logic signed [33:0] DEG360 = 34'sd23592960;

  localparam logic signed [17:0] ONE_Q16 = 18'sd65536;

  localparam logic [3:0]         CORDIC_LAST = 4'd15;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  typedef struct packed {
    logic              start;
    logic signed [31:0] angle;
  } cordic_req_t;

  typedef struct packed {
    logic              done;
    logic signed [31:0] cos_v;
    logic signed [31:0] sin_v;
  } cordic_res_t;

  // arctangent of 2^-i in Q.16 degrees
  function automatic logic signed [31:0] atan_q16(input logic [3:0] i);
    logic signed [31:0] v;
    case (i)
      4'd0:    v = 32'sd2949120;
      4'd1:    v = 32'sd1740967;
      4'd2:    v = 32'sd919879;
      4'd3:    v = 32'sd466945;
      4'd4:    v = 32'sd234379;
      4'd5:    v = 32'sd117304;
      4'd6:    v = 32'sd58666;
      4'd7:    v = 32'sd29335;
      4'd8:    v = 32'sd14668;
      4'd9:    v = 32'sd7334;
      4'd10:   v = 32'sd3667;
      4'd11:   v = 32'sd1833;
      4'd12:   v = 32'sd917;
      4'd13:   v = 32'sd458;
      4'd14:   v = 32'sd229;
      default: v = 32'sd115;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/fcvm_mul.sv =====
// Shared registered 32x32 signed multiplier.
`timescale 1ns / 1ps
module fcvm_mul (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic signed [63:0] p_r
);

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= a * b;
    end
  end

endmodule

// ===== rtl/fcvm_cordic.sv =====
// Iterative 16-step rotation CORDIC: sine and cosine of a Q.16 degree angle in Q2.30.
`timescale 1ns / 1ps
module fcvm_cordic (
  input  logic                clk,
  input  logic                rst_n,
  input  fcvm_pkg::cordic_req_t req,
  output fcvm_pkg::cordic_res_t res
);

  logic               busy_r;
  logic               done_r;
  logic [3:0]         step_r;
  logic signed [33:0] x_r;
  logic signed [33:0] y_r;
  logic signed [31:0] a_r;
  logic               neg_r;
  logic signed [33:0] xs;
  logic signed [33:0] ys;
  logic signed [33:0] xo;
  logic signed [33:0] yo;

  assign xs = x_r >>> step_r;
  assign ys = y_r >>> step_r;
  assign xo = neg_r ? -x_r : x_r;
  assign yo = neg_r ? -y_r : y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 4'd1;
        if (step_r == fcvm_pkg::CORDIC_LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      x_r <= fcvm_pkg::CORDIC_GAIN;
      y_r <= '0;
      // fold into +-90 degrees, negate both results afterwards
      if (req.angle > fcvm_pkg::DEG90) begin
        a_r   <= req.angle - fcvm_pkg::DEG180;
        neg_r <= 1'b1;
      end else if (req.angle < -fcvm_pkg::DEG90) begin
        a_r   <= req.angle + fcvm_pkg::DEG180;
        neg_r <= 1'b1;
      end else begin
        a_r   <= req.angle;
        neg_r <= 1'b0;
      end
    end else if (busy_r) begin
      if (!a_r[31]) begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        a_r <= a_r - fcvm_pkg::atan_q16(step_r);
      end else begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        a_r <= a_r + fcvm_pkg::atan_q16(step_r);
      end
    end
  end

  assign res.done  = done_r;
  assign res.cos_v = xo[31:0];
  assign res.sin_v = yo[31:0];

endmodule

// ===== rtl/fly_camera_view_matrix.sv =====
// Top level: fly camera sequencer, state and view matrix row output.
`timescale 1ns / 1ps
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+--------------------------------------
//  in_      | input     | in_valid / in_ready    | command, delta_time, key_mask, mouse, new xyz
//  out_     | output    | out_valid / out_ready  | row_index, elem_0..elem_3, last
//  cfg_     | input     | cfg_valid / cfg_ready  | cfg_index, cfg_data (always ready)
//
//  Steps per transaction: mouse does two 16-step CORDIC runs on one unit,
//  four wrap steps and five vector steps; keyboard tick steps through each key,
//  moving along the held ones, then the three dot products on the shared multiplier,
//  then 4 output rows; set position the three dot products plus the 4 rows.
//  One item at a time; in_ready is low from accept until the last row is taken or a turn ends.
//  Reset is synchronous: registers, angles, vectors and position go to defaults.
//  Output stalls hold the row on the port; nothing else advances meanwhile.
module fly_camera_view_matrix (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     in_command,
  input  logic [15:0]                    in_delta_time,
  input  logic [5:0]                     in_key_mask,
  input  logic signed [15:0]             in_mouse_dx,
  input  logic signed [15:0]             in_mouse_dy,
  input  logic signed [31:0]             in_new_x,
  input  logic signed [31:0]             in_new_y,
  input  logic signed [31:0]             in_new_z,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [1:0]                     out_row_index,
  output logic signed [31:0]             out_elem_0,
  output logic signed [31:0]             out_elem_1,
  output logic signed [31:0]             out_elem_2,
  output logic signed [31:0]             out_elem_3,
  output logic                           out_last,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [fcvm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                    cfg_data
);

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_M_DX    = 4'd1;
  localparam logic [3:0] ST_M_DY    = 4'd2;
  localparam logic [3:0] ST_M_PIT   = 4'd3;
  localparam logic [3:0] ST_M_WRAP  = 4'd4;
  localparam logic [3:0] ST_C_YS    = 4'd5;
  localparam logic [3:0] ST_C_YW    = 4'd6;
  localparam logic [3:0] ST_C_PS    = 4'd7;
  localparam logic [3:0] ST_C_PW    = 4'd8;
  localparam logic [3:0] ST_VEC     = 4'd9;
  localparam logic [3:0] ST_K_VEL   = 4'd10;
  localparam logic [3:0] ST_K_VR    = 4'd11;
  localparam logic [3:0] ST_K_MOV   = 4'd12;
  localparam logic [3:0] ST_DOT     = 4'd13;
  localparam logic [3:0] ST_DOT_RND = 4'd14;
  localparam logic [3:0] ST_EMIT    = 4'd15;

  // control
  logic [3:0] state_r;
  logic [2:0] cnt_r;     // key, wrap step, vector step or matrix row
  logic [1:0] comp_r;    // vector component
  logic       ph_r;      // 0: issue multiply, 1: use product
  logic       ovalid_r;
  logic [1:0] orow_r;

  // architectural state
  logic [15:0]        sens_r;
  logic [15:0]        speed_r;
  logic signed [31:0] pos_r [3];
  logic signed [31:0] yaw_r;
  logic signed [31:0] pitch_r;
  logic signed [17:0] fwd_r [3];
  logic signed [17:0] rgt_r [3];
  logic signed [17:0] up_r  [3];

  // working registers
  logic [15:0]        dt_r;
  logic [5:0]         keys_r;
  logic signed [15:0] mdx_r;
  logic signed [15:0] mdy_r;
  logic signed [33:0] ytmp_r;
  logic [24:0]        vel_r;
  logic signed [31:0] cy_r, sy_r, cp_r, sp_r;
  logic signed [51:0] acc_r;
  logic signed [31:0] t_r [3];

  // shared multiplier
  logic               mul_en;
  logic signed [31:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [63:0] mul_p;

  fcvm_pkg::cordic_req_t c_req;
  fcvm_pkg::cordic_res_t c_res;

  fcvm_mul u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (mul_p)
  );

  fcvm_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (c_req),
    .res   (c_res)
  );

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (v > 36'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -36'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [17:0] rnd14(input logic signed [32:0] v);
    logic signed [32:0] s;
    s = (v + 33'sd8192) >>> 14;
    return s[17:0];
  endfunction

  // --- datapath helpers ---
  logic signed [63:0] mouse_sh;
  logic signed [33:0] mouse_off;
  logic signed [33:0] ptmp;
  logic signed [31:0] pclamp;
  logic signed [33:0] wrap_sub;
  logic signed [33:0] wrap_val;
  logic signed [33:0] yaw_new;
  logic signed [63:0] vp_sel;
  logic signed [63:0] vp_rnd;
  logic signed [17:0] mv_vec;
  logic               mv_minus;
  logic signed [63:0] mv_sh;
  logic signed [33:0] mv_sum;
  logic signed [17:0] dot_vec;
  logic signed [51:0] dot_sel;
  logic signed [51:0] dot_sh;
  logic signed [63:0] vel_sh;

  assign mouse_sh  = (mul_p + 64'sd8) >>> 4;
  assign mouse_off = mouse_sh[33:0];
  assign ptmp      = $signed({{2{pitch_r[31]}}, pitch_r}) + mouse_off;
  assign pclamp    = (ptmp > $signed({{2{fcvm_pkg::DEG89[31]}}, fcvm_pkg::DEG89})) ?
                     fcvm_pkg::DEG89 :
                     (ptmp < -$signed({{2{fcvm_pkg::DEG89[31]}}, fcvm_pkg::DEG89})) ?
                     -fcvm_pkg::DEG89 : ptmp[31:0];

  // yaw wrap: offset to non-negative, then subtract 8, 4, 2, 1 turns
  assign wrap_sub = fcvm_pkg::DEG360 <<< cnt_r[1:0];
  assign wrap_val = (ytmp_r >= wrap_sub) ? ytmp_r - wrap_sub : ytmp_r;
  assign yaw_new  = wrap_val - $signed({{2{fcvm_pkg::DEG180[31]}}, fcvm_pkg::DEG180});

  // forward/up products, the up terms are negated before rounding
  assign vp_sel = (cnt_r >= 3'd3) ? -mul_p : mul_p;
  assign vp_rnd = (vp_sel + (64'sd1 <<< 43)) >>> 44;

  assign vel_sh = (mul_p + 64'sd128) >>> 8;

  always_comb begin
    case (cnt_r)
      3'd0, 3'd1: mv_vec = fwd_r[comp_r];
      3'd2, 3'd3: mv_vec = rgt_r[comp_r];
      default:    mv_vec = (comp_r == 2'd1) ? fcvm_pkg::ONE_Q16 : 18'sd0;
    endcase
  end
  assign mv_minus = (cnt_r == 3'd1) || (cnt_r == 3'd2) || (cnt_r == 3'd5);
  assign mv_sh    = (mul_p + 64'sd32768) >>> 16;
  assign mv_sum   = mv_minus ?
                    $signed({{2{pos_r[comp_r][31]}}, pos_r[comp_r]}) - mv_sh[33:0] :
                    $signed({{2{pos_r[comp_r][31]}}, pos_r[comp_r]}) + mv_sh[33:0];

  always_comb begin
    case (cnt_r)
      3'd0:    dot_vec = rgt_r[comp_r];
      3'd1:    dot_vec = up_r[comp_r];
      default: dot_vec = fwd_r[comp_r];
    endcase
  end
  assign dot_sel = (cnt_r == 3'd2) ? acc_r : -acc_r;
  assign dot_sh  = (dot_sel + 52'sd32768) >>> 16;

  // multiplier operand select
  always_comb begin
    mul_en = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    case (state_r)
      ST_M_DX: begin
        mul_en = 1'b1;
        mul_a  = {{16{mdx_r[15]}}, mdx_r};
        mul_b  = {16'd0, sens_r};
      end
      ST_M_DY: begin
        mul_en = 1'b1;
        mul_a  = {{16{mdy_r[15]}}, mdy_r};
        mul_b  = {16'd0, sens_r};
      end
      ST_VEC: begin
        mul_en = 1'b1;
        mul_a  = cnt_r[0] ? sy_r : cy_r;
        mul_b  = cnt_r[1] ? sp_r : cp_r;
      end
      ST_K_VEL: begin
        mul_en = 1'b1;
        mul_a  = {16'd0, speed_r};
        mul_b  = {16'd0, dt_r};
      end
      ST_K_MOV: begin
        mul_en = !ph_r;
        mul_a  = {{14{mv_vec[17]}}, mv_vec};
        mul_b  = {7'd0, vel_r};
      end
      ST_DOT: begin
        mul_en = !ph_r;
        mul_a  = {{14{dot_vec[17]}}, dot_vec};
        mul_b  = pos_r[comp_r];
      end
      default: mul_en = 1'b0;
    endcase
  end

  always_comb begin
    c_req.start = (state_r == ST_C_YS) || (state_r == ST_C_PS);
    c_req.angle = (state_r == ST_C_PS) ? pitch_r : yaw_r;
  end

  // sequencer and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      cnt_r    <= '0;
      comp_r   <= '0;
      ph_r     <= 1'b0;
      ovalid_r <= 1'b0;
      orow_r   <= '0;
      sens_r   <= fcvm_pkg::SENS_RST;
      speed_r  <= fcvm_pkg::SPEED_RST;
      pos_r    <= '{default: 32'sd0};
      yaw_r    <= -fcvm_pkg::DEG90;
      pitch_r  <= '0;
      fwd_r    <= '{18'sd0, 18'sd0, -fcvm_pkg::ONE_Q16};
      rgt_r    <= '{fcvm_pkg::ONE_Q16, 18'sd0, 18'sd0};
      up_r     <= '{18'sd0, fcvm_pkg::ONE_Q16, 18'sd0};
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          fcvm_pkg::CFG_SENS:  sens_r  <= cfg_data;
          fcvm_pkg::CFG_SPEED: speed_r <= cfg_data;
          default: ;
        endcase
      end
      unique case (state_r)
        ST_IDLE: begin
          cnt_r  <= '0;
          comp_r <= '0;
          ph_r   <= 1'b0;
          if (in_valid) begin
            case (in_command)
              fcvm_pkg::CMD_KEY:   state_r <= ST_K_VEL;
              fcvm_pkg::CMD_MOUSE: state_r <= ST_M_DX;
              fcvm_pkg::CMD_SETPOS: begin
                pos_r[0] <= in_new_x;
                pos_r[1] <= in_new_y;
                pos_r[2] <= in_new_z;
                state_r  <= ST_DOT;
              end
              default: state_r <= ST_IDLE;
            endcase
          end
        end
        ST_M_DX: state_r <= ST_M_DY;
        ST_M_DY: state_r <= ST_M_PIT;
        ST_M_PIT: begin
          pitch_r <= pclamp;
          cnt_r   <= 3'd3;
          state_r <= ST_M_WRAP;
        end
        ST_M_WRAP: begin
          if (cnt_r == 3'd0) begin
            yaw_r   <= yaw_new[31:0];
            state_r <= ST_C_YS;
          end else begin
            cnt_r <= cnt_r - 3'd1;
          end
        end
        ST_C_YS: state_r <= ST_C_YW;
        ST_C_YW: begin
          if (c_res.done) begin
            state_r <= ST_C_PS;
          end
        end
        ST_C_PS: state_r <= ST_C_PW;
        ST_C_PW: begin
          if (c_res.done) begin
            cnt_r   <= '0;
            state_r <= ST_VEC;
          end
        end
        ST_VEC: begin
          cnt_r <= cnt_r + 3'd1;
          case (cnt_r)
            3'd1: fwd_r[0] <= vp_rnd[17:0];
            3'd2: fwd_r[2] <= vp_rnd[17:0];
            3'd3: up_r[0]  <= vp_rnd[17:0];
            3'd4: begin
              up_r[2]  <= vp_rnd[17:0];
              fwd_r[1] <= rnd14($signed({sp_r[31], sp_r}));
              rgt_r[0] <= rnd14(-$signed({sy_r[31], sy_r}));
              rgt_r[1] <= 18'sd0;
              rgt_r[2] <= rnd14($signed({cy_r[31], cy_r}));
              up_r[1]  <= rnd14($signed({cp_r[31], cp_r}));
              state_r  <= ST_IDLE;
            end
            default: ;
          endcase
        end
        ST_K_VEL: state_r <= ST_K_VR;
        ST_K_VR: begin
          cnt_r   <= '0;
          comp_r  <= '0;
          ph_r    <= 1'b0;
          state_r <= ST_K_MOV;
        end
        ST_K_MOV: begin
          if (!keys_r[cnt_r] || ph_r) begin
            if (ph_r) begin
              pos_r[comp_r] <= sat32({{2{mv_sum[33]}}, mv_sum});
            end
            ph_r <= 1'b0;
            if (!keys_r[cnt_r] || comp_r == 2'd2) begin
              comp_r <= '0;
              if (cnt_r == 3'd5) begin
                cnt_r   <= '0;
                state_r <= ST_DOT;
              end else begin
                cnt_r <= cnt_r + 3'd1;
              end
            end else begin
              comp_r <= comp_r + 2'd1;
            end
          end else begin
            ph_r <= 1'b1;
          end
        end
        ST_DOT: begin
          ph_r <= !ph_r;
          if (ph_r) begin
            if (comp_r == 2'd2) begin
              comp_r  <= '0;
              state_r <= ST_DOT_RND;
            end else begin
              comp_r <= comp_r + 2'd1;
            end
          end
        end
        ST_DOT_RND: begin
          if (cnt_r == 3'd2) begin
            ovalid_r <= 1'b1;
            orow_r   <= '0;
            state_r  <= ST_EMIT;
          end else begin
            cnt_r   <= cnt_r + 3'd1;
            state_r <= ST_DOT;
          end
        end
        ST_EMIT: begin
          if (out_ready) begin
            if (orow_r == 2'd3) begin
              ovalid_r <= 1'b0;
              state_r  <= ST_IDLE;
            end else begin
              orow_r <= orow_r + 2'd1;
            end
          end
        end
      endcase
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) begin
      dt_r   <= in_delta_time;
      keys_r <= in_key_mask;
      mdx_r  <= in_mouse_dx;
      mdy_r  <= in_mouse_dy;
    end
    if (state_r == ST_M_DY) begin
      ytmp_r <= $signed({{2{yaw_r[31]}}, yaw_r}) + mouse_off
              + $signed({{2{fcvm_pkg::DEG180[31]}}, fcvm_pkg::DEG180})
              + (fcvm_pkg::DEG360 <<< 3);
    end
    if (state_r == ST_M_WRAP) begin
      ytmp_r <= wrap_val;
    end
    if (state_r == ST_C_YW && c_res.done) begin
      cy_r <= c_res.cos_v;
      sy_r <= c_res.sin_v;
    end
    if (state_r == ST_C_PW && c_res.done) begin
      cp_r <= c_res.cos_v;
      sp_r <= c_res.sin_v;
    end
    if (state_r == ST_K_VR) begin
      vel_r <= vel_sh[24:0];
    end
    if (state_r == ST_DOT && ph_r) begin
      acc_r <= ((comp_r == 2'd0) ? 52'sd0 : acc_r) + mul_p[51:0];
    end
    if (state_r == ST_DOT_RND) begin
      t_r[cnt_r[1:0]] <= sat32(dot_sh[35:0]);
    end
  end

  // output row select; sources are static while a row is shown
  logic signed [31:0] nf0, nf1, nf2;
  assign nf0 = -$signed({{14{fwd_r[0][17]}}, fwd_r[0]});
  assign nf1 = -$signed({{14{fwd_r[1][17]}}, fwd_r[1]});
  assign nf2 = -$signed({{14{fwd_r[2][17]}}, fwd_r[2]});

  always_comb begin
    case (orow_r)
      2'd0: begin
        out_elem_0 = {{14{rgt_r[0][17]}}, rgt_r[0]};
        out_elem_1 = {{14{rgt_r[1][17]}}, rgt_r[1]};
        out_elem_2 = {{14{rgt_r[2][17]}}, rgt_r[2]};
        out_elem_3 = t_r[0];
      end
      2'd1: begin
        out_elem_0 = {{14{up_r[0][17]}}, up_r[0]};
        out_elem_1 = {{14{up_r[1][17]}}, up_r[1]};
        out_elem_2 = {{14{up_r[2][17]}}, up_r[2]};
        out_elem_3 = t_r[1];
      end
      2'd2: begin
        out_elem_0 = nf0;
        out_elem_1 = nf1;
        out_elem_2 = nf2;
        out_elem_3 = t_r[2];
      end
      default: begin
        out_elem_0 = '0;
        out_elem_1 = '0;
        out_elem_2 = '0;
        out_elem_3 = {{14{fcvm_pkg::ONE_Q16[17]}}, fcvm_pkg::ONE_Q16};
      end
    endcase
  end

  assign in_ready      = (state_r == ST_IDLE);
  assign cfg_ready     = 1'b1;
  assign out_valid     = ovalid_r;
  assign out_row_index = orow_r;
  assign out_last      = (orow_r == 2'd3);

endmodule

// ===== rtl/fcvm_checker.sv =====
// Port-level checks for the fly camera view matrix engine, bound to the top level.
`timescale 1ns / 1ps
module fcvm_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_row_index,
  input logic       out_last
);

  // a shown row stays until taken
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("row dropped while stalled");

  // rows come in order, back to back
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=>
      out_valid && (out_row_index == $past(out_row_index) + 2'd1))
    else $error("row order broken");

  // no transaction taken while rows are pending
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input ready during output");

  // matrix ends after the last row
  a_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last |=> !out_valid)
    else $error("extra row after last");

  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == (out_row_index == 2'd3)))
    else $error("last flag on wrong row");

endmodule

bind fly_camera_view_matrix fcvm_checker u_fcvm_checker (.*);

// ===== bench/fcvm_checker.sv =====
// Channel monitor, camera state predictor and view matrix row comparator.
`timescale 1ns / 1ps
module fcvm_scoreboard (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic [1:0]                      in_command,
  input  logic [15:0]                     in_delta_time,
  input  logic [5:0]                      in_key_mask,
  input  logic signed [15:0]              in_mouse_dx,
  input  logic signed [15:0]              in_mouse_dy,
  input  logic signed [31:0]              in_new_x,
  input  logic signed [31:0]              in_new_y,
  input  logic signed [31:0]              in_new_z,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic [1:0]                      out_row_index,
  input  logic signed [31:0]              out_elem_0,
  input  logic signed [31:0]              out_elem_1,
  input  logic signed [31:0]              out_elem_2,
  input  logic signed [31:0]              out_elem_3,
  input  logic                            out_last,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [fcvm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [15:0]                     cfg_data,
  output int                              errors,
  output int                              rows_pending,
  output int                              rows_seen
);

  typedef struct packed {
    logic [1:0]         row;
    logic signed [31:0] e0;
    logic signed [31:0] e1;
    logic signed [31:0] e2;
    logic signed [31:0] e3;
    logic               last;
  } view_row_t;

  view_row_t   row_queue[$];
  logic [15:0] sens_q, speed_q;
  longint      cam_pos[3];
  longint      yaw_q, pitch_q;
  longint      fwd[3], rgt[3], upv[3];

  function automatic longint round_shift(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // 16-step rotation in Q2.30, folds angles beyond +-90 degrees
  task automatic sin_cos(input longint ang, output longint c, output longint s);
    longint x, y, nx, a;
    bit     flip;
    x = longint'(fcvm_pkg::CORDIC_GAIN);
    y = 0;
    a = ang;
    flip = 1'b0;
    if (a > longint'(fcvm_pkg::DEG90)) begin
      a -= longint'(fcvm_pkg::DEG180);
      flip = 1'b1;
    end else if (a < -longint'(fcvm_pkg::DEG90)) begin
      a += longint'(fcvm_pkg::DEG180);
      flip = 1'b1;
    end
    for (int i = 0; i < 16; i++) begin
      if (a >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        a -= longint'(fcvm_pkg::atan_q16(i[3:0]));
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        a += longint'(fcvm_pkg::atan_q16(i[3:0]));
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  task automatic step_along(input longint v[3], input longint vel, input bit minus);
    longint d;
    for (int k = 0; k < 3; k++) begin
      d = round_shift(v[k] * vel, 16);
      cam_pos[k] = clip32(cam_pos[k] + (minus ? -d : d));
    end
  endtask

  function automatic longint translation(longint v[3], bit minus);
    longint acc;
    acc = 0;
    for (int k = 0; k < 3; k++) acc += v[k] * cam_pos[k];
    return clip32(round_shift(minus ? -acc : acc, 16));
  endfunction

  task automatic push_matrix();
    view_row_t r;
    r = '{2'd0, 32'(rgt[0]), 32'(rgt[1]), 32'(rgt[2]), 32'(translation(rgt, 1'b1)), 1'b0};
    row_queue.push_back(r);
    r = '{2'd1, 32'(upv[0]), 32'(upv[1]), 32'(upv[2]), 32'(translation(upv, 1'b1)), 1'b0};
    row_queue.push_back(r);
    r = '{2'd2, 32'(-fwd[0]), 32'(-fwd[1]), 32'(-fwd[2]), 32'(translation(fwd, 1'b0)),
          1'b0};
    row_queue.push_back(r);
    r = '{2'd3, 32'sd0, 32'sd0, 32'sd0, 32'sd65536, 1'b1};
    row_queue.push_back(r);
  endtask

  task automatic turn(input logic signed [15:0] dx, input logic signed [15:0] dy);
    longint ox, oy, y, p, cy, sy, cp, sp;
    ox = round_shift(longint'(dx) * longint'(sens_q), 4);
    oy = round_shift(longint'(dy) * longint'(sens_q), 4);
    y = (yaw_q + ox + longint'(fcvm_pkg::DEG180)) % longint'(fcvm_pkg::DEG360);
    if (y < 0) y += longint'(fcvm_pkg::DEG360);
    yaw_q = y - longint'(fcvm_pkg::DEG180);
    p = pitch_q + oy;
    if (p > longint'(fcvm_pkg::DEG89)) p = longint'(fcvm_pkg::DEG89);
    if (p < -longint'(fcvm_pkg::DEG89)) p = -longint'(fcvm_pkg::DEG89);
    pitch_q = p;
    sin_cos(yaw_q, cy, sy);
    sin_cos(pitch_q, cp, sp);
    fwd[0] = round_shift(cy * cp, 44);
    fwd[1] = round_shift(sp, 14);
    fwd[2] = round_shift(sy * cp, 44);
    rgt[0] = round_shift(-sy, 14);
    rgt[1] = 0;
    rgt[2] = round_shift(cy, 14);
    upv[0] = round_shift(-(cy * sp), 44);
    upv[1] = round_shift(cp, 14);
    upv[2] = round_shift(-(sy * sp), 44);
  endtask

  task automatic key_tick(input logic [15:0] dt, input logic [5:0] keys);
    longint vel;
    longint world_up[3];
    world_up = '{0, 65536, 0};
    vel = round_shift(longint'(speed_q) * longint'(dt), 8);
    if (keys[0]) step_along(fwd, vel, 1'b0);
    if (keys[1]) step_along(fwd, vel, 1'b1);
    if (keys[2]) step_along(rgt, vel, 1'b1);
    if (keys[3]) step_along(rgt, vel, 1'b0);
    if (keys[4]) step_along(world_up, vel, 1'b0);
    if (keys[5]) step_along(world_up, vel, 1'b1);
    push_matrix();
  endtask

  always @(posedge clk) begin
    view_row_t want;
    if (!rst_n) begin
      row_queue.delete();
      errors = 0;
      rows_seen = 0;
      sens_q = fcvm_pkg::SENS_RST;
      speed_q = fcvm_pkg::SPEED_RST;
      cam_pos = '{0, 0, 0};
      yaw_q = -longint'(fcvm_pkg::DEG90);
      pitch_q = 0;
      fwd = '{0, 0, -65536};
      rgt = '{65536, 0, 0};
      upv = '{0, 65536, 0};
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == fcvm_pkg::CFG_SENS) sens_q = cfg_data;
        else if (cfg_index == fcvm_pkg::CFG_SPEED) speed_q = cfg_data;
      end
      if (in_valid && in_ready) begin
        case (in_command)
          fcvm_pkg::CMD_KEY:   key_tick(in_delta_time, in_key_mask);
          fcvm_pkg::CMD_MOUSE: turn(in_mouse_dx, in_mouse_dy);
          fcvm_pkg::CMD_SETPOS: begin
            cam_pos = '{longint'(in_new_x), longint'(in_new_y), longint'(in_new_z)};
            push_matrix();
          end
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        rows_seen++;
        if (row_queue.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected row %0d at %0t", out_row_index, $realtime);
        end else begin
          want = row_queue.pop_front();
          if (want.row !== out_row_index || want.e0 !== out_elem_0 ||
              want.e1 !== out_elem_1 || want.e2 !== out_elem_2 ||
              want.e3 !== out_elem_3 || want.last !== out_last) begin
            errors++;
            if (errors <= 10)
              $display("row mismatch: exp %0d %0d %0d %0d %0d %0d got %0d %0d %0d %0d %0d %0d",
                       want.row, want.e0, want.e1, want.e2, want.e3, want.last,
                       out_row_index, out_elem_0, out_elem_1, out_elem_2,
                       out_elem_3, out_last);
          end
        end
      end
    end
    rows_pending = row_queue.size();
  end

endmodule

// ===== bench/fly_camera_view_matrix_test.sv =====
// Stimulus, handshake pacing and verdict for the fly camera view matrix engine.
`timescale 1ns / 1ps
module fly_camera_view_matrix_test;

  // command code with no function and a register index with no register
  localparam logic [1:0]                     CMD_UNUSED   = 2'd3;
  localparam logic [fcvm_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED = 4'hF;

  logic                           clk, rst_n;
  logic                           in_valid, in_ready;
  logic [1:0]                     in_command;
  logic [15:0]                    in_delta_time;
  logic [5:0]                     in_key_mask;
  logic signed [15:0]             in_mouse_dx, in_mouse_dy;
  logic signed [31:0]             in_new_x, in_new_y, in_new_z;
  logic                           out_valid, out_ready;
  logic [1:0]                     out_row_index;
  logic signed [31:0]             out_elem_0, out_elem_1, out_elem_2, out_elem_3;
  logic                           out_last;
  logic                           cfg_valid, cfg_ready;
  logic [fcvm_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [15:0]                    cfg_data;

  int  errors, rows_pending, rows_seen;
  int  items_sent, turns_sent;
  int  cycle_count;
  bit  calm;          // pacing off for a whole phase
  bit  hold_request;  // receiver takes one long break
  bit  hold_done;

  fly_camera_view_matrix dut (.*);

  fcvm_scoreboard chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // hard stop far beyond the slowest legal run
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > 1500000) begin
        $display("fly_camera_view_matrix verification failed");
        $finish;
      end
    end
  end

  function automatic int pace();
    return calm ? 0 : $urandom_range(0, 19);
  endfunction

  // one input transaction; valid stays up into the next call when no gap follows
  task automatic send(input logic [1:0] cmd, input logic [15:0] dt, input logic [5:0] keys,
                      input logic [15:0] dx, input logic [15:0] dy,
                      input logic [31:0] nx, input logic [31:0] ny, input logic [31:0] nz);
    int gap;
    gap = pace();
    if (gap > 0) begin
      in_valid = 0;
      repeat (gap) @(negedge clk);
    end
    in_command = cmd;
    in_delta_time = dt;
    in_key_mask = keys;
    in_mouse_dx = dx;
    in_mouse_dy = dy;
    in_new_x = nx;
    in_new_y = ny;
    in_new_z = nz;
    in_valid = 1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    items_sent++;
    if (cmd == fcvm_pkg::CMD_MOUSE) turns_sent++;
  endtask

  task automatic key_tick(input logic [15:0] dt, input logic [5:0] keys);
    send(fcvm_pkg::CMD_KEY, dt, keys, 16'($urandom), 16'($urandom),
         $urandom, $urandom, $urandom);
  endtask

  task automatic turn(input logic [15:0] dx, input logic [15:0] dy);
    send(fcvm_pkg::CMD_MOUSE, 16'($urandom), 6'($urandom), dx, dy,
         $urandom, $urandom, $urandom);
  endtask

  task automatic place(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
    send(fcvm_pkg::CMD_SETPOS, 16'($urandom), 6'($urandom), 16'($urandom), 16'($urandom),
         x, y, z);
  endtask

  // drain everything, then allow for a turn still in flight (no rows from it)
  task automatic settle();
    in_valid = 0;
    while (rows_pending != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  task automatic write_reg(input logic [fcvm_pkg::CFG_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_index = idx;
    cfg_data = val;
    cfg_valid = 1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 0;
  endtask

  function automatic logic [31:0] near_coord();
    if ($urandom_range(0, 3) == 0) return $urandom;
    return $urandom_range(0, 4000000) - 2000000;
  endfunction

  function automatic logic [15:0] mouse_step();
    if ($urandom_range(0, 5) == 0) return 16'($urandom);
    return 16'($urandom_range(0, 800) - 400);
  endfunction

  // mostly movement and turning with random content, some teleports and noise
  task automatic random_burst(input int count);
    int pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45)
        key_tick(($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3000)),
                 6'($urandom));
      else if (pick < 80) turn(mouse_step(), mouse_step());
      else if (pick < 95) place(near_coord(), near_coord(), near_coord());
      else send(CMD_UNUSED, 16'($urandom), 6'($urandom), 16'($urandom), 16'($urandom),
                $urandom, $urandom, $urandom);
    end
  endtask

  // result side: random stalls per row, plus one long hold-off on request
  initial begin
    int gap;
    out_ready = 0;
    hold_done = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_request && !hold_done) begin
        out_ready = 0;
        repeat (400) @(negedge clk);
        hold_done = 1;
      end
      gap = pace();
      if (gap > 0) begin
        out_ready = 0;
        repeat (gap) @(negedge clk);
      end
      out_ready = 1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    in_valid = 0;
    in_command = fcvm_pkg::CMD_KEY;
    in_delta_time = 0;
    in_key_mask = 0;
    in_mouse_dx = 0;
    in_mouse_dy = 0;
    in_new_x = 0;
    in_new_y = 0;
    in_new_z = 0;
    cfg_valid = 0;
    cfg_index = fcvm_pkg::CFG_SENS;
    cfg_data = 0;
    calm = 0;
    hold_request = 0;
    items_sent = 0;
    turns_sent = 0;
    rst_n = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed: reset pose, each key alone, all keys, time extremes
    key_tick(16'd0, 6'd0);
    for (int k = 0; k < 6; k++) key_tick(16'd65535, 6'(1 << k));
    key_tick(16'd65535, 6'h3F);
    key_tick(16'd0, 6'h3F);
    // teleports to the corners; translation saturates
    place(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
    place(32'h80000000, 32'h80000000, 32'h80000000);
    place(32'h0, 32'h0, 32'h0);
    // turning: pitch clamps both ways, yaw wraps past +-180
    turn(16'h7FFF, 16'h7FFF);
    key_tick(16'd40000, 6'h0F);
    turn(16'h8000, 16'h8000);
    turn(16'h8000, 16'h0000);
    turn(16'd0, 16'd0);
    key_tick(16'd20000, 6'h3F);
    send(CMD_UNUSED, 16'hFFFF, 6'h3F, 16'h7FFF, 16'h7FFF, 32'h1, 32'h1, 32'h1);
    key_tick(16'd1000, 6'h01);
    settle();

    // sensitivity and speed at both extremes, plus an unmapped index
    write_reg(fcvm_pkg::CFG_SENS, 16'hFFFF);
    write_reg(fcvm_pkg::CFG_SPEED, 16'hFFFF);
    write_reg(CFG_UNMAPPED, 16'h1234);
    turn(16'h7FFF, 16'h1234);
    key_tick(16'hFFFF, 6'h3F);
    turn(16'h8000, 16'h8000);
    key_tick(16'hFFFF, 6'h05);
    random_burst(40);
    settle();

    write_reg(fcvm_pkg::CFG_SENS, 16'd0);
    write_reg(fcvm_pkg::CFG_SPEED, 16'd0);
    calm = 1;
    random_burst(40);
    settle();

    // defaults again, with the receiver taking one long break mid-phase
    calm = 0;
    write_reg(fcvm_pkg::CFG_SENS, fcvm_pkg::SENS_RST);
    write_reg(fcvm_pkg::CFG_SPEED, fcvm_pkg::SPEED_RST);
    random_burst(20);
    hold_request = 1;
    random_burst(60);
    settle();

    for (int ph = 0; ph < 4; ph++) begin
      write_reg(fcvm_pkg::CFG_SENS, 16'($urandom));
      write_reg(fcvm_pkg::CFG_SPEED, 16'($urandom));
      write_reg(4'($urandom_range(2, 15)), 16'($urandom));
      calm = (ph == 2);
      random_burst(45);
      settle();
    end

    $display("covered %0d input transactions (%0d turns), %0d matrix rows checked,",
             items_sent, turns_sent, rows_seen);
    $display("config extremes and random settings, long output stall, random pacing");
    if (errors == 0 && rows_pending == 0) begin
      $display("fly_camera_view_matrix verification clean");
    end else begin
      $display("fly_camera_view_matrix verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/fcvm_pkg.sv
rtl/fcvm_mul.sv
rtl/fcvm_cordic.sv
rtl/fly_camera_view_matrix.sv
rtl/fcvm_checker.sv
bench/fcvm_checker.sv
bench/fly_camera_view_matrix_test.sv
